// ===== src/fwdb_pkg.sv =====
package fwdb_pkg;

	// The number of wheels follows from the fixed set of speed and current ports.
	localparam int unsigned NUM_WHEELS = 4;

	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned CURRENT_W = 16;
	localparam int unsigned GAIN_W    = 8;
	localparam int unsigned LIMIT_W   = 15;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 15;

	typedef logic signed [SPEED_W-1:0]   speed_t;
	typedef logic signed [CURRENT_W-1:0] current_t;

	// Register indices on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAMPING_GAIN    = 3'd0,
		REG_CURRENT_LIMIT   = 3'd1,
		REG_LOW_SPEED_LIMIT = 3'd2,
		REG_LOW_SPEED_BAND  = 3'd3,
		REG_STOP_BAND       = 3'd4,
		REG_RAMP_STEP       = 3'd5
	} cfg_index_t;

	// The full set of configuration registers, as seen by the datapath.
	typedef struct packed {
		logic [GAIN_W-1:0]  damping_gain;
		logic [LIMIT_W-1:0] current_limit;
		logic [LIMIT_W-1:0] low_speed_current_limit;
		logic [LIMIT_W-1:0] low_speed_band;
		logic [LIMIT_W-1:0] stop_band;
		logic [LIMIT_W-1:0] ramp_step;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		damping_gain:            8'd12,
		current_limit:           15'd8000,
		low_speed_current_limit: 15'd4500,
		low_speed_band:          15'd300,
		stop_band:               15'd120,
		ramp_step:               15'd1200
	};

endpackage

// ===== src/fwdb_stop_detect.sv =====
module fwdb_stop_detect (
	input  fwdb_pkg::speed_t                speed [fwdb_pkg::NUM_WHEELS],
	input  logic [fwdb_pkg::LIMIT_W-1:0]    stop_band,
	output logic                            stopped
);

	logic [fwdb_pkg::SPEED_W:0]          mag [fwdb_pkg::NUM_WHEELS];
	logic [fwdb_pkg::NUM_WHEELS-1:0]     in_band;

	// A wheel is inside the stop band when its speed magnitude is at most the band.
	always_comb begin
		for (int w = 0; w < int'(fwdb_pkg::NUM_WHEELS); w++) begin
			mag[w] = speed[w][fwdb_pkg::SPEED_W-1]
				? 17'(-{speed[w][fwdb_pkg::SPEED_W-1], speed[w]})
				: {1'b0, speed[w]};
			in_band[w] = (mag[w] <= {2'b00, stop_band});
		end
	end

	// The chassis counts as stopped only when every wheel is inside the band.
	assign stopped = &in_band;

endmodule

// ===== src/fwdb_wheel.sv =====
module fwdb_wheel (
	input  fwdb_pkg::speed_t   speed,
	input  fwdb_pkg::current_t last,
	input  fwdb_pkg::cfg_t     cfg,
	output fwdb_pkg::current_t next
);

	logic        [16:0] mag;
	logic        [14:0] limit;
	logic signed [24:0] product;
	logic signed [24:0] target;
	logic signed [24:0] limit_pos;
	logic signed [24:0] limit_neg;
	logic signed [15:0] clamped;
	logic signed [17:0] last_x;
	logic signed [17:0] delta;
	logic signed [17:0] step_pos;
	logic signed [17:0] step_neg;
	logic signed [17:0] ramped;

	// Damping target, clamped to the limit that applies at this speed.
	always_comb begin
		mag = speed[15] ? 17'(-{speed[15], speed}) : {1'b0, speed};
		product = 25'(signed'({1'b0, cfg.damping_gain})) * 25'(speed);
		target = -product;
		limit = (mag < {2'b00, cfg.low_speed_band})
			? cfg.low_speed_current_limit : cfg.current_limit;
		limit_pos = 25'(signed'({1'b0, limit}));
		limit_neg = -limit_pos;
		if (target > limit_pos) begin
			clamped = 16'(limit_pos);
		end else if (target < limit_neg) begin
			clamped = 16'(limit_neg);
		end else begin
			clamped = 16'(target);
		end
	end

	// Slew limit against the wheel's last current.
	always_comb begin
		last_x = 18'(last);
		delta = 18'(clamped) - last_x;
		step_pos = 18'(signed'({1'b0, cfg.ramp_step}));
		step_neg = -step_pos;
		priority if (delta > step_pos) begin
			ramped = last_x + step_pos;
		end else if (delta < step_neg) begin
			ramped = last_x + step_neg;
		end else begin
			ramped = 18'(clamped);
		end
	end

	assign next = 16'(ramped);

endmodule

// ===== src/four_wheel_damping_brake.sv =====
// Channel  | Direction | Handshake           | Payload
// input    | in        | in_valid, in_stall   | speed_wheel0..3 (16-bit signed)
// output   | out       | out_valid, out_stall | current_wheel0..3 (16-bit signed), all_stopped
// config   | in        | cfg_write            | cfg_index (3 bits), cfg_data (15 bits)
//
// One request is taken in every cycle while in_stall is low.
// The speed register feeds one combinational pass (multiply, clamp, ramp) into the
// result register, which also updates the stored last currents for the next request.
// Reset clears the handshake state and the last currents and loads the register defaults.
// A stalled result holds, the speed register still takes one more request, then in_stall rises.
module four_wheel_damping_brake (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  fwdb_pkg::speed_t                    speed_wheel0,
	input  fwdb_pkg::speed_t                    speed_wheel1,
	input  fwdb_pkg::speed_t                    speed_wheel2,
	input  fwdb_pkg::speed_t                    speed_wheel3,

	output logic                                out_valid,
	input  logic                                out_stall,
	output fwdb_pkg::current_t                  current_wheel0,
	output fwdb_pkg::current_t                  current_wheel1,
	output fwdb_pkg::current_t                  current_wheel2,
	output fwdb_pkg::current_t                  current_wheel3,
	output logic                                all_stopped,

	input  logic                                cfg_write,
	input  logic [fwdb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fwdb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fwdb_pkg::cfg_t     cfg_q;
	fwdb_pkg::speed_t   speed_s1       [fwdb_pkg::NUM_WHEELS];
	logic               valid_s1;
	fwdb_pkg::current_t current_s2     [fwdb_pkg::NUM_WHEELS];
	logic               stopped_s2;
	logic               valid_s2;
	fwdb_pkg::current_t last_current_q [fwdb_pkg::NUM_WHEELS];
	fwdb_pkg::current_t next_current   [fwdb_pkg::NUM_WHEELS];
	logic               stopped;
	logic               out_free;
	logic               advance;
	logic               in_accept;

	// Configuration register writes; unknown indices are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fwdb_pkg::CFG_RESET;
		end else if (cfg_write) begin
			unique case (fwdb_pkg::cfg_index_t'(cfg_index))
				fwdb_pkg::REG_DAMPING_GAIN:    cfg_q.damping_gain <= cfg_data[7:0];
				fwdb_pkg::REG_CURRENT_LIMIT:   cfg_q.current_limit <= cfg_data;
				fwdb_pkg::REG_LOW_SPEED_LIMIT: cfg_q.low_speed_current_limit <= cfg_data;
				fwdb_pkg::REG_LOW_SPEED_BAND:  cfg_q.low_speed_band <= cfg_data;
				fwdb_pkg::REG_STOP_BAND:       cfg_q.stop_band <= cfg_data;
				fwdb_pkg::REG_RAMP_STEP:       cfg_q.ramp_step <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken this cycle.
	assign out_free  = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Speed register.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			speed_s1[0] <= speed_wheel0;
			speed_s1[1] <= speed_wheel1;
			speed_s1[2] <= speed_wheel2;
			speed_s1[3] <= speed_wheel3;
		end
	end

	// Datapath: stop detection and one damping unit per wheel.
	fwdb_stop_detect u_stop (
		.speed     (speed_s1),
		.stop_band (cfg_q.stop_band),
		.stopped   (stopped)
	);

	for (genvar w = 0; w < fwdb_pkg::NUM_WHEELS; w++) begin : g_wheel
		fwdb_wheel u_wheel (
			.speed (speed_s1[w]),
			.last  (last_current_q[w]),
			.cfg   (cfg_q),
			.next  (next_current[w])
		);
	end

	// Stored last currents; a full stop clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < int'(fwdb_pkg::NUM_WHEELS); w++) begin
				last_current_q[w] <= '0;
			end
		end else if (advance) begin
			for (int w = 0; w < int'(fwdb_pkg::NUM_WHEELS); w++) begin
				last_current_q[w] <= stopped ? '0 : next_current[w];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int w = 0; w < int'(fwdb_pkg::NUM_WHEELS); w++) begin
				current_s2[w] <= stopped ? '0 : next_current[w];
			end
			stopped_s2 <= stopped;
		end
	end

	assign out_valid      = valid_s2;
	assign current_wheel0 = current_s2[0];
	assign current_wheel1 = current_s2[1];
	assign current_wheel2 = current_s2[2];
	assign current_wheel3 = current_s2[3];
	assign all_stopped    = stopped_s2;

	// The stored currents always match the result on show.
	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (last_current_q[0] == current_s2[0] && last_current_q[1] == current_s2[1]
			&& last_current_q[2] == current_s2[2] && last_current_q[3] == current_s2[3]))
		else $error("stored last currents differ from the shown result");

	// A stopped result carries zero currents.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && stopped_s2) |-> (current_s2[0] == '0 && current_s2[1] == '0
			&& current_s2[2] == '0 && current_s2[3] == '0))
		else $error("stopped result with non-zero current");

	// Input is held off only while both the speed register and the result register are occupied.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with free pipeline");

	// A request moved forward is shown in the next cycle.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced request lost");

endmodule
